FILE: sv/lfc_pkg.sv
// Shared constants, types and coefficient lookup for the two-channel lux datapath
package lfc_pkg;

  localparam int CHANNEL_BITS = 16;
  localparam int CH_SHIFT     = 10;
  localparam int RATIO_SHIFT  = 9;
  localparam int LUX_SHIFT    = 14;
  localparam int LUX_W        = 16;
  localparam int SCALE_W      = 19;
  localparam int MUL_W        = CHANNEL_BITS + SCALE_W;
  localparam int CH_W         = MUL_W - CH_SHIFT;
  localparam int REM_W        = CH_W + 1;
  localparam int QBITS        = RATIO_SHIFT + 2;
  localparam int COEF_W       = 10;
  localparam int PROD_W       = CH_W + COEF_W;
  localparam int SEGMENTS     = 7;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEG_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_GAIN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PACKAGE_CS = 2'd2;

  localparam logic [1:0] MODE_13MS  = 2'd0;
  localparam logic [1:0] MODE_101MS = 2'd1;
  localparam logic [1:0] MODE_402MS = 2'd2;

  localparam logic [SCALE_W-1:0] TINT_13MS_SCALE  = 19'h07517;
  localparam logic [SCALE_W-1:0] TINT_101MS_SCALE = 19'h00FE7;
  localparam logic [SCALE_W-1:0] CHSCALE_UNIT     = SCALE_W'(1) << CH_SHIFT;

  localparam logic [QBITS-1:0] SEG_K [2][SEGMENTS] = '{
    '{11'h040, 11'h080, 11'h0C0, 11'h100, 11'h138, 11'h19A, 11'h29A},
    '{11'h043, 11'h085, 11'h0C8, 11'h10A, 11'h14D, 11'h19A, 11'h29A}
  };
  localparam logic [COEF_W-1:0] SEG_B [2][SEGMENTS] = '{
    '{10'h1F2, 10'h214, 10'h23F, 10'h270, 10'h16F, 10'h0D2, 10'h018},
    '{10'h204, 10'h228, 10'h253, 10'h282, 10'h177, 10'h101, 10'h037}
  };
  localparam logic [COEF_W-1:0] SEG_M [2][SEGMENTS] = '{
    '{10'h1BE, 10'h2D1, 10'h37B, 10'h3FE, 10'h1FC, 10'h0FB, 10'h012},
    '{10'h1AD, 10'h2C1, 10'h363, 10'h3DF, 10'h1DD, 10'h127, 10'h02B}
  };

  typedef struct packed {
    logic [CH_W-1:0]  ch0;
    logic [CH_W-1:0]  ch1;
    logic [REM_W-1:0] rem;
    logic [QBITS-1:0] quo;
    logic             zero;
    logic             sat;
  } lfc_item_t;

  typedef struct packed {
    logic [COEF_W-1:0] b;
    logic [COEF_W-1:0] m;
  } lfc_coef_t;

  function automatic lfc_coef_t lfc_coef(input logic pk, input logic [QBITS-1:0] ratio);
    lfc_coef_t c;
    logic      hit;
    c   = '0;
    hit = 1'b0;
    for (int i = 0; i < SEGMENTS; i++) begin
      if (!hit && (ratio <= SEG_K[pk][i])) begin
        c.b = SEG_B[pk][i];
        c.m = SEG_M[pk][i];
        hit = 1'b1;
      end
    end
    return c;
  endfunction

endpackage

FILE: sv/lfc_div_cell.sv
// One restoring-division cell: resolves one ratio bit and hands the item on
module lfc_div_cell
  import lfc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      adv_i,
  input  logic      valid_i,
  input  lfc_item_t item_i,
  output logic      valid_o,
  output lfc_item_t item_o
);

  logic             bit_d;
  logic [REM_W-1:0] diff_d;
  lfc_item_t        item_d;
  logic             valid_q;
  lfc_item_t        item_q;

  always_comb begin
    bit_d       = item_i.rem >= REM_W'(item_i.ch0);
    diff_d      = bit_d ? (item_i.rem - REM_W'(item_i.ch0)) : item_i.rem;
    item_d      = item_i;
    item_d.rem  = {diff_d[REM_W-2:0], 1'b0};
    item_d.quo  = {item_i.quo[QBITS-2:0], bit_d};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

FILE: sv/lfc_lux_stage.sv
// Coefficient lookup, channel products and rounded, clamped lux output register
module lfc_lux_stage
  import lfc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic             pkg_i,
  input  logic             valid_i,
  input  lfc_item_t        item_i,
  output logic             valid_o,
  output logic [LUX_W-1:0] lux_o
);

  logic [QBITS:0]          rnd_d;
  logic [QBITS-1:0]        ratio_d;
  lfc_coef_t               coef_d;
  logic                    va_q;
  lfc_coef_t               coef_q;
  logic [CH_W-1:0]         ch0_q;
  logic [CH_W-1:0]         ch1_q;
  logic                    vb_q;
  logic [PROD_W-1:0]       pos_q;
  logic [PROD_W-1:0]       neg_q;
  logic [PROD_W:0]         sum_d;
  logic [PROD_W-LUX_SHIFT:0] shr_d;
  logic [LUX_W-1:0]        lux_d;
  logic                    out_valid_q;
  logic [LUX_W-1:0]        lux_q;

  always_comb begin
    rnd_d   = ({1'b0, item_i.quo} + (QBITS+1)'(1)) >> 1;
    ratio_d = item_i.zero ? '0 : rnd_d[QBITS-1:0];
    coef_d  = lfc_coef(pkg_i, ratio_d);
    if (item_i.sat && !item_i.zero) begin
      coef_d = '0;
    end
  end

  always_comb begin
    sum_d = {1'b0, pos_q - neg_q} + ((PROD_W+1)'(1) << (LUX_SHIFT - 1));
    shr_d = sum_d[PROD_W:LUX_SHIFT];
    if (neg_q >= pos_q) begin
      lux_d = '0;
    end else if (|shr_d[PROD_W-LUX_SHIFT:LUX_W]) begin
      lux_d = '1;
    end else begin
      lux_d = shr_d[LUX_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q        <= 1'b0;
      vb_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv_i) begin
      va_q        <= valid_i;
      vb_q        <= va_q;
      out_valid_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      coef_q <= coef_d;
      ch0_q  <= item_i.ch0;
      ch1_q  <= item_i.ch1;
      pos_q  <= PROD_W'(ch0_q) * PROD_W'(coef_q.b);
      neg_q  <= PROD_W'(ch1_q) * PROD_W'(coef_q.m);
      lux_q  <= lux_d;
    end
  end

  assign valid_o = out_valid_q;
  assign lux_o   = lux_q;

endmodule

FILE: sv/lux_from_two_channels_unit.sv
// Two-channel lux calculation: top level with channel scaling and the divider cell row
//
// Input channel: in_valid_i with full_count_i and ir_count_i; an item is taken at a
// rising edge with in_valid_i high and in_stall_o low. Output channel: out_valid_o
// with lux_o; taken at an edge with out_valid_o high and out_stall_i low.
// Configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i (0 integration
// mode, 1 high gain, 2 package table); write only while no item is in flight.
// One item per cycle is taken while the output does not stall. The ratio comes from
// a row of 11 division cells, one quotient bit each, with the channel scaling
// multipliers ahead and the coefficient products behind.
// Stall: when the output register is full and out_stall_i is high the whole row
// holds and in_stall_o rises in the same cycle; no item is lost or repeated.
// Reset: all valid flags clear, registers return to 402 ms, 1x gain, T package.
module lux_from_two_channels_unit
  import lfc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [15:0]           full_count_i,
  input  logic [15:0]           ir_count_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [LUX_W-1:0]      lux_o
);

  logic [1:0]         integ_mode_q;
  logic               high_gain_q;
  logic               package_cs_q;
  logic               adv;
  logic [SCALE_W-1:0] scale_d;
  logic [MUL_W-1:0]   prod0_d;
  logic [MUL_W-1:0]   prod1_d;
  logic               s0_valid_q;
  logic [CH_W-1:0]    ch0_q;
  logic [CH_W-1:0]    ch1_q;
  lfc_item_t          prep_d;
  logic               prep_vld_q;
  lfc_item_t          prep_item_q;
  logic               cell_vld  [QBITS+1];
  lfc_item_t          cell_item [QBITS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_mode_q <= MODE_402MS;
      high_gain_q  <= 1'b0;
      package_cs_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_INTEG_MODE: integ_mode_q <= cfg_data_i[1:0];
        CFG_HIGH_GAIN:  high_gain_q  <= cfg_data_i[0];
        CFG_PACKAGE_CS: package_cs_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign adv        = !out_valid_o || !out_stall_i;
  assign in_stall_o = !adv;

  always_comb begin
    unique case (integ_mode_q)
      MODE_13MS:  scale_d = TINT_13MS_SCALE;
      MODE_101MS: scale_d = TINT_101MS_SCALE;
      default:    scale_d = CHSCALE_UNIT;
    endcase
    if (!high_gain_q) begin
      scale_d = scale_d << 4;
    end
    prod0_d = MUL_W'(full_count_i[CHANNEL_BITS-1:0]) * MUL_W'(scale_d);
    prod1_d = MUL_W'(ir_count_i[CHANNEL_BITS-1:0]) * MUL_W'(scale_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (adv) begin
      s0_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ch0_q <= prod0_d[MUL_W-1:CH_SHIFT];
      ch1_q <= prod1_d[MUL_W-1:CH_SHIFT];
    end
  end

  always_comb begin
    prep_d.ch0  = ch0_q;
    prep_d.ch1  = ch1_q;
    prep_d.rem  = REM_W'(ch1_q);
    prep_d.quo  = '0;
    prep_d.zero = (ch0_q == '0);
    prep_d.sat  = REM_W'(ch1_q) >= {ch0_q, 1'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prep_vld_q <= 1'b0;
    end else if (adv) begin
      prep_vld_q <= s0_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      prep_item_q <= prep_d;
    end
  end

  assign cell_vld[0]  = prep_vld_q;
  assign cell_item[0] = prep_item_q;

  for (genvar g = 0; g < QBITS; g++) begin : g_cell
    lfc_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .valid_i (cell_vld[g]),
      .item_i  (cell_item[g]),
      .valid_o (cell_vld[g+1]),
      .item_o  (cell_item[g+1])
    );
  end

  lfc_lux_stage u_lux (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .pkg_i   (package_cs_q),
    .valid_i (cell_vld[QBITS]),
    .item_i  (cell_item[QBITS]),
    .valid_o (out_valid_o),
    .lux_o   (lux_o)
  );

endmodule

FILE: bench/tb_top.sv
// Self-checking bench for lux_from_two_channels_unit: directed table, random items, predictor
module tb_top
  import lfc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_CYCLES   = 300;
  localparam int BLOCK_ITEMS   = 70;

  localparam logic [1:0]           MODE_SPARE = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  localparam logic [63:0] SCALE_13MS  = 64'h7517;
  localparam logic [63:0] SCALE_101MS = 64'h0FE7;
  localparam logic [63:0] SCALE_UNIT  = 64'h0400;

  localparam logic [0:6][10:0] KNEE_T = {11'h040, 11'h080, 11'h0C0, 11'h100,
                                         11'h138, 11'h19A, 11'h29A};
  localparam logic [0:6][10:0] KNEE_C = {11'h043, 11'h085, 11'h0C8, 11'h10A,
                                         11'h14D, 11'h19A, 11'h29A};
  localparam logic [0:6][9:0]  VIS_T  = {10'h1F2, 10'h214, 10'h23F, 10'h270,
                                         10'h16F, 10'h0D2, 10'h018};
  localparam logic [0:6][9:0]  VIS_C  = {10'h204, 10'h228, 10'h253, 10'h282,
                                         10'h177, 10'h101, 10'h037};
  localparam logic [0:6][9:0]  IR_T   = {10'h1BE, 10'h2D1, 10'h37B, 10'h3FE,
                                         10'h1FC, 10'h0FB, 10'h012};
  localparam logic [0:6][9:0]  IR_C   = {10'h1AD, 10'h2C1, 10'h363, 10'h3DF,
                                         10'h1DD, 10'h127, 10'h02B};

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e                kind;
    logic [15:0]              full;
    logic [15:0]              ir;
    logic                     known;
    logic [15:0]              lux;
    logic [CFG_IDX_W-1:0]     idx;
    logic [CFG_DATA_W-1:0]    val;
  } stim_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [15:0]           full_count_i;
  logic [15:0]           ir_count_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [LUX_W-1:0]      lux_o;

  logic [1:0]  cur_mode;
  logic        cur_gain;
  logic        cur_pkg;
  logic [15:0] lux_expected [$];
  int          n_mismatch;
  int          n_cycles;
  int          tx_idle_pct;
  int          rx_idle_pct;
  bit          hold_req;
  stim_row_t   directed [27];

  lux_from_two_channels_unit u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .full_count_i (full_count_i),
    .ir_count_i   (ir_count_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .lux_o        (lux_o)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  function automatic logic [15:0] predict_lux(input logic [15:0] full, input logic [15:0] ir);
    logic [63:0] scale, ch0, ch1, ratio, pos, neg, val;
    logic [9:0]  b, m;
    logic [10:0] knee;
    bit          hit;
    case (cur_mode)
      MODE_13MS:  scale = SCALE_13MS;
      MODE_101MS: scale = SCALE_101MS;
      default:    scale = SCALE_UNIT;
    endcase
    if (!cur_gain) scale = scale << 4;
    ch0 = (64'(full) * scale) >> 10;
    ch1 = (64'(ir) * scale) >> 10;
    ratio = (ch0 != 0) ? (ch1 << 10) / ch0 : 64'd0;
    ratio = (ratio + 1) >> 1;
    b = '0;
    m = '0;
    hit = 1'b0;
    for (int i = 0; i < 7; i++) begin
      knee = cur_pkg ? KNEE_C[i] : KNEE_T[i];
      if (!hit && ratio <= 64'(knee)) begin
        b = cur_pkg ? VIS_C[i] : VIS_T[i];
        m = cur_pkg ? IR_C[i] : IR_T[i];
        hit = 1'b1;
      end
    end
    pos = ch0 * 64'(b);
    neg = ch1 * 64'(m);
    if (neg >= pos) return 16'd0;
    val = (pos - neg + 64'd8192) >> 14;
    return (val > 64'hFFFF) ? 16'hFFFF : val[15:0];
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] want,
                                 input logic [15:0] got);
    n_mismatch++;
    if (n_mismatch <= 10)
      $display("mismatch at %0t (%s): expected lux %0d, got %0d", $realtime, what, want, got);
  endtask

  // compare on the falling edge; the result is taken at the next rising edge
  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (lux_expected.size() == 0) begin
        report_mismatch("unexpected item", 16'd0, lux_o);
      end else begin
        if (lux_o !== lux_expected[0]) report_mismatch("lux", lux_expected[0], lux_o);
        void'(lux_expected.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("lux_from_two_channels_unit regression: fail");
      $finish;
    end
  end

  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < rx_idle_pct);
      end
    end
  end

  task automatic send_item(input logic [15:0] full, input logic [15:0] ir,
                           input logic known, input logic [15:0] lux);
    bit taken;
    in_valid_i   <= 1'b1;
    full_count_i <= full;
    ir_count_i   <= ir;
    do begin
      @(negedge clk_i);
      taken = (in_stall_o === 1'b0);
      @(posedge clk_i);
    end while (!taken);
    lux_expected.push_back(known ? lux : predict_lux(full, ir));
  endtask

  task automatic wait_results_drained();
    while (lux_expected.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_INTEG_MODE: cur_mode = val[1:0];
      CFG_HIGH_GAIN:  cur_gain = val[0];
      CFG_PACKAGE_CS: cur_pkg  = val[0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic run_block(input int n_items, input bit with_hold);
    logic [15:0] full, ir;
    int          frac;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait_results_drained();
    write_reg(CFG_INTEG_MODE, 2'($urandom_range(0, 3)));
    write_reg(CFG_HIGH_GAIN, 2'($urandom_range(0, 3)));
    write_reg(CFG_PACKAGE_CS, 2'($urandom_range(0, 3)));
    if (with_hold) hold_req = 1'b1;
    for (int i = 0; i < n_items; i++) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          full = 16'($urandom);
          ir   = 16'($urandom);
        end
        2: begin
          full = 16'($urandom_range(0, 15));
          ir   = 16'($urandom_range(0, 15));
        end
        3: begin
          full = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
          ir   = $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom);
        end
        default: begin
          full = 16'($urandom_range(1, 65535) >> $urandom_range(0, 12));
          frac = $urandom_range(0, 1400);
          ir   = ((full * frac) / 1000 > 65535) ? 16'hFFFF : 16'((full * frac) / 1000);
        end
      endcase
      send_item(full, ir, 1'b0, 16'd0);
      if ($urandom_range(0, 99) < tx_idle_pct) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
      end
    end
  endtask

  initial begin
    directed = '{
      '{ROW_ITEM, 16'd0,     16'd0,     1'b1, 16'd0,     CFG_INTEG_MODE, 2'd0},
      '{ROW_ITEM, 16'd0,     16'd65535, 1'b1, 16'd0,     CFG_INTEG_MODE, 2'd0},
      '{ROW_ITEM, 16'd1,     16'd65535, 1'b1, 16'd0,     CFG_INTEG_MODE, 2'd0},
      '{ROW_ITEM, 16'd65535, 16'd0,     1'b0, 16'd0,     CFG_INTEG_MODE, 2'd0},
      '{ROW_ITEM, 16'd65535, 16'd65535, 1'b0, 16'd0,     CFG_INTEG_MODE, 2'd0},
      '{ROW_ITEM, 16'd1024,  16'd128,   1'b0, 16'd0,     CFG_INTEG_MODE, 2'd0},
      '{ROW_ITEM, 16'd1024,  16'd129,   1'b0, 16'd0,     CFG_INTEG_MODE, 2'd0},
      '{ROW_ITEM, 16'd1000,  16'd300,   1'b0, 16'd0,     CFG_INTEG_MODE, 2'd0},
      '{ROW_ITEM, 16'd1000,  16'd450,   1'b0, 16'd0,     CFG_INTEG_MODE, 2'd0},
      '{ROW_ITEM, 16'd1000,  16'd550,   1'b0, 16'd0,     CFG_INTEG_MODE, 2'd0},
      '{ROW_ITEM, 16'd1000,  16'd700,   1'b0, 16'd0,     CFG_INTEG_MODE, 2'd0},
      '{ROW_ITEM, 16'd1000,  16'd1000,  1'b0, 16'd0,     CFG_INTEG_MODE, 2'd0},
      '{ROW_CFG,  16'd0,     16'd0,     1'b0, 16'd0,     CFG_PACKAGE_CS, 2'd1},
      '{ROW_ITEM, 16'd1000,  16'd1295,  1'b1, 16'd0,     CFG_INTEG_MODE, 2'd0},
      '{ROW_ITEM, 16'd1000,  16'd200,   1'b0, 16'd0,     CFG_INTEG_MODE, 2'd0},
      '{ROW_CFG,  16'd0,     16'd0,     1'b0, 16'd0,     CFG_INTEG_MODE, MODE_13MS},
      '{ROW_ITEM, 16'd65535, 16'd0,     1'b1, 16'd65535, CFG_INTEG_MODE, 2'd0},
      '{ROW_CFG,  16'd0,     16'd0,     1'b0, 16'd0,     CFG_HIGH_GAIN,  2'd1},
      '{ROW_ITEM, 16'd65535, 16'd32768, 1'b0, 16'd0,     CFG_INTEG_MODE, 2'd0},
      '{ROW_CFG,  16'd0,     16'd0,     1'b0, 16'd0,     CFG_INTEG_MODE, MODE_101MS},
      '{ROW_ITEM, 16'd43690, 16'd21845, 1'b0, 16'd0,     CFG_INTEG_MODE, 2'd0},
      '{ROW_CFG,  16'd0,     16'd0,     1'b0, 16'd0,     CFG_INTEG_MODE, MODE_SPARE},
      '{ROW_ITEM, 16'd21845, 16'd5461,  1'b0, 16'd0,     CFG_INTEG_MODE, 2'd0},
      '{ROW_CFG,  16'd0,     16'd0,     1'b0, 16'd0,     CFG_HIGH_GAIN,  2'b10},
      '{ROW_CFG,  16'd0,     16'd0,     1'b0, 16'd0,     CFG_UNUSED,     2'b11},
      '{ROW_CFG,  16'd0,     16'd0,     1'b0, 16'd0,     CFG_PACKAGE_CS, 2'b10},
      '{ROW_ITEM, 16'd12345, 16'd6789,  1'b0, 16'd0,     CFG_INTEG_MODE, 2'd0}
    };
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = '0;
    cfg_data_i   = '0;
    in_valid_i   = 1'b0;
    full_count_i = '0;
    ir_count_i   = '0;
    cur_mode     = MODE_402MS;
    cur_gain     = 1'b0;
    cur_pkg      = 1'b0;
    n_mismatch   = 0;
    n_cycles     = 0;
    tx_idle_pct  = 0;
    rx_idle_pct  = 0;
    hold_req     = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_CFG) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        wait_results_drained();
        write_reg(directed[i].idx, directed[i].val);
      end else begin
        send_item(directed[i].full, directed[i].ir, directed[i].known, directed[i].lux);
      end
    end

    tx_idle_pct = 25;
    rx_idle_pct = 52;
    run_block(BLOCK_ITEMS, 1'b0);
    run_block(BLOCK_ITEMS, 1'b1);
    run_block(BLOCK_ITEMS, 1'b0);
    tx_idle_pct = 52;
    rx_idle_pct = 25;
    repeat (3) run_block(BLOCK_ITEMS, 1'b0);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (3) run_block(BLOCK_ITEMS, 1'b0);

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait_results_drained();
    if (n_mismatch == 0 && lux_expected.size() == 0) begin
      $display("lux_from_two_channels_unit regression: pass");
    end else begin
      $display("lux_from_two_channels_unit regression: fail");
    end
    $finish;
  end

endmodule
